// ===== design/oaht_pkg.sv =====
// Shared types and codes for the open-address hash table.
package oaht_pkg;

    localparam int KEY_W   = 64;
    localparam int VAL_W   = 64;
    localparam int MODE_W  = 2;
    localparam int STAT_W  = 3;
    localparam int CNT_W   = 11;
    localparam int HOME_MULT  = 73;
    localparam int PROBE_STEP = 5009;
    localparam logic [CNT_W-1:0] LOAD_LIMIT_RESET = 11'd870;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STAT_W-1:0] ST_PRESENT   = 3'd1;
    localparam logic [STAT_W-1:0] ST_RESERVED  = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STAT_W-1:0] ST_REMOVED   = 3'd4;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd5;
    localparam logic [STAT_W-1:0] ST_FOUND     = 3'd6;

    localparam logic [VAL_W-1:0] VAL_EMPTY   = 64'd0;
    localparam logic [VAL_W-1:0] VAL_DELETED = 64'd1;

    typedef enum logic [2:0] {
        OP_INSERT,
        OP_REMOVE,
        OP_LOOKUP,
        OP_REJECT,
        OP_NOOP
    } op_kind_t;

    typedef struct packed {
        op_kind_t          kind;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
    } req_t;

endpackage

// ===== design/oaht_front.sv =====
// Front end: takes requests, classifies them and computes the home slot.
module oaht_front #(
    parameter int CAPACITY = 1024,
    parameter int IDX_W    = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [oaht_pkg::MODE_W-1:0] mode,
    input  logic [oaht_pkg::KEY_W-1:0]  key,
    input  logic [oaht_pkg::VAL_W-1:0]  value,
    output logic                        front_busy,
    input  logic                        q_full,
    output logic                        q_push,
    output oaht_pkg::req_t              q_req,
    output logic [IDX_W-1:0]            q_home
);

    localparam bit POW2 = (CAPACITY & (CAPACITY - 1)) == 0;
    localparam int TW = IDX_W + 4;
    localparam logic [TW-1:0] CAP_T = TW'(CAPACITY);

    typedef enum logic [1:0] {
        F_IDLE,
        F_HASH,
        F_PUSH
    } fstate_t;

    fstate_t                      state_reg;
    oaht_pkg::req_t               req_reg;
    logic [oaht_pkg::KEY_W-1:0]   prod_reg;
    logic [IDX_W-1:0]             rem_reg;
    logic [IDX_W-1:0]             rem_next;
    logic [3:0]                   nib_reg;
    logic [oaht_pkg::KEY_W-1:0]   prod_next;
    oaht_pkg::op_kind_t           kind_next;
    logic                         accept;

    assign accept     = start && (state_reg == F_IDLE);
    assign front_busy = (state_reg != F_IDLE);
    assign prod_next  = key * oaht_pkg::KEY_W'(oaht_pkg::HOME_MULT);

    always_comb
    begin
        priority if (mode == oaht_pkg::MODE_INSERT)
        begin
            if (value == oaht_pkg::VAL_EMPTY || value == oaht_pkg::VAL_DELETED)
                kind_next = oaht_pkg::OP_REJECT;
            else
                kind_next = oaht_pkg::OP_INSERT;
        end
        else if (mode == oaht_pkg::MODE_REMOVE)
            kind_next = oaht_pkg::OP_REMOVE;
        else if (mode == oaht_pkg::MODE_LOOKUP)
            kind_next = oaht_pkg::OP_LOOKUP;
        else
            kind_next = oaht_pkg::OP_NOOP;
    end

    // Four bits of the product a cycle, most significant first.
    always_comb
    begin
        logic [TW-1:0] t;
        t = {rem_reg, prod_reg[oaht_pkg::KEY_W-1 -: 4]};
        for (int i = 3; i >= 0; i--)
        begin
            if (t >= (CAP_T << i))
                t = t - (CAP_T << i);
        end
        rem_next = t[IDX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            nib_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                begin
                    if (accept)
                    begin
                        req_reg.kind  <= kind_next;
                        req_reg.key   <= key;
                        req_reg.value <= value;
                        prod_reg      <= prod_next;
                        rem_reg       <= '0;
                        nib_reg       <= '0;
                        state_reg     <= POW2 ? F_PUSH : F_HASH;
                    end
                end
                F_HASH:
                begin
                    rem_reg  <= rem_next;
                    prod_reg <= {prod_reg[oaht_pkg::KEY_W-5:0], 4'd0};
                    nib_reg  <= nib_reg + 4'd1;
                    if (nib_reg == 4'd15)
                        state_reg <= F_PUSH;
                end
                F_PUSH:
                begin
                    if (!q_full)
                        state_reg <= F_IDLE;
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

    assign q_push = (state_reg == F_PUSH) && !q_full;
    assign q_req  = req_reg;
    assign q_home = POW2 ? prod_reg[IDX_W-1:0] : rem_reg;

endmodule

// ===== design/oaht_queue.sv =====
// Two-entry request queue between front end and back end.
module oaht_queue #(
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              full,
    output logic              empty
);

    logic [DATA_W-1:0] slot_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// ===== design/oaht_back.sv =====
// Back end: slot memories, clearing pass and the probe sequencer.
module oaht_back #(
    parameter int CAPACITY = 1024,
    parameter int IDX_W    = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [oaht_pkg::CNT_W-1:0]   load_limit,
    input  logic                         q_empty,
    input  oaht_pkg::req_t               q_req,
    input  logic [IDX_W-1:0]             q_home,
    output logic                         q_pop,
    output logic                         clearing,
    output logic                         done,
    output logic [oaht_pkg::STAT_W-1:0]  status,
    output logic [oaht_pkg::VAL_W-1:0]   value_out,
    output logic [oaht_pkg::CNT_W-1:0]   item_count
);

    localparam int CNTW = $clog2(CAPACITY + 1);
    localparam int CMPW = (CNTW + 1 > oaht_pkg::CNT_W) ? CNTW + 1 : oaht_pkg::CNT_W;
    localparam int STEP = oaht_pkg::PROBE_STEP % CAPACITY;
    localparam logic [IDX_W-1:0] LAST = IDX_W'(CAPACITY - 1);

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_READ,
        B_EVAL
    } bstate_t;

    bstate_t                       state_reg;
    oaht_pkg::req_t                req_reg;
    logic [IDX_W-1:0]              slot_reg;
    logic [IDX_W-1:0]              n_reg;
    logic [CNTW-1:0]               live_reg;
    logic [CNTW-1:0]               del_reg;
    logic                          done_reg;
    logic [oaht_pkg::STAT_W-1:0]   status_reg;
    logic [oaht_pkg::VAL_W-1:0]    value_out_reg;
    logic [oaht_pkg::CNT_W-1:0]    item_count_reg;

    logic [oaht_pkg::VAL_W-1:0]    vmem [CAPACITY];
    logic [oaht_pkg::KEY_W-1:0]    kmem [CAPACITY];
    logic [oaht_pkg::VAL_W-1:0]    val_q;
    logic [oaht_pkg::KEY_W-1:0]    key_q;

    logic                          v_we;
    logic                          k_we;
    logic [oaht_pkg::VAL_W-1:0]    v_wd;
    logic [IDX_W:0]                step_sum;
    logic [IDX_W-1:0]              slot_step;
    logic                          is_live;
    logic                          at_limit;

    assign step_sum  = {1'b0, slot_reg} + (IDX_W+1)'(STEP);
    assign slot_step = (step_sum >= (IDX_W+1)'(CAPACITY))
                     ? IDX_W'(step_sum - (IDX_W+1)'(CAPACITY)) : step_sum[IDX_W-1:0];
    assign is_live   = (val_q != oaht_pkg::VAL_EMPTY) && (val_q != oaht_pkg::VAL_DELETED);
    assign at_limit  = (CMPW'(live_reg) + CMPW'(del_reg)) >= CMPW'(load_limit);

    assign clearing = (state_reg == B_CLEAR);
    assign q_pop    = (state_reg == B_IDLE) && !q_empty;

    always_comb
    begin
        v_we = 1'b0;
        k_we = 1'b0;
        v_wd = oaht_pkg::VAL_EMPTY;
        if (state_reg == B_CLEAR)
            v_we = 1'b1;
        else if (state_reg == B_EVAL)
        begin
            if (req_reg.kind == oaht_pkg::OP_INSERT && !is_live
                && !(val_q == oaht_pkg::VAL_EMPTY && at_limit))
            begin
                v_we = 1'b1;
                k_we = 1'b1;
                v_wd = req_reg.value;
            end
            else if (req_reg.kind == oaht_pkg::OP_REMOVE && is_live && key_q == req_reg.key)
            begin
                v_we = 1'b1;
                v_wd = oaht_pkg::VAL_DELETED;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (v_we)
            vmem[slot_reg] <= v_wd;
        if (k_we)
            kmem[slot_reg] <= req_reg.key;
        val_q <= vmem[slot_reg];
        key_q <= kmem[slot_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_CLEAR;
            slot_reg  <= '0;
            n_reg     <= '0;
            live_reg  <= '0;
            del_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                B_CLEAR:
                begin
                    slot_reg <= slot_reg + IDX_W'(1);
                    if (slot_reg == LAST)
                        state_reg <= B_IDLE;
                end
                B_IDLE:
                begin
                    if (!q_empty)
                    begin
                        req_reg        <= q_req;
                        value_out_reg  <= '0;
                        item_count_reg <= oaht_pkg::CNT_W'(live_reg);
                        unique case (q_req.kind)
                            oaht_pkg::OP_REJECT:
                            begin
                                done_reg   <= 1'b1;
                                status_reg <= oaht_pkg::ST_RESERVED;
                            end
                            oaht_pkg::OP_INSERT, oaht_pkg::OP_REMOVE, oaht_pkg::OP_LOOKUP:
                            begin
                                slot_reg  <= q_home;
                                n_reg     <= '0;
                                state_reg <= B_READ;
                            end
                            default:
                            begin
                                done_reg   <= 1'b1;
                                status_reg <= oaht_pkg::ST_NOT_FOUND;
                            end
                        endcase
                    end
                end
                B_READ:
                begin
                    state_reg <= B_EVAL;
                end
                B_EVAL:
                begin
                    priority if (req_reg.kind == oaht_pkg::OP_INSERT && !is_live)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= B_IDLE;
                        if (val_q == oaht_pkg::VAL_EMPTY && at_limit)
                            status_reg <= oaht_pkg::ST_FULL;
                        else
                        begin
                            status_reg     <= oaht_pkg::ST_INSERTED;
                            live_reg       <= live_reg + CNTW'(1);
                            item_count_reg <= oaht_pkg::CNT_W'(live_reg + CNTW'(1));
                            if (val_q == oaht_pkg::VAL_DELETED)
                                del_reg <= del_reg - CNTW'(1);
                        end
                    end
                    else if (req_reg.kind == oaht_pkg::OP_INSERT && val_q == req_reg.value)
                    begin
                        done_reg   <= 1'b1;
                        status_reg <= oaht_pkg::ST_PRESENT;
                        state_reg  <= B_IDLE;
                    end
                    else if (req_reg.kind != oaht_pkg::OP_INSERT
                             && val_q == oaht_pkg::VAL_EMPTY)
                    begin
                        done_reg   <= 1'b1;
                        status_reg <= oaht_pkg::ST_NOT_FOUND;
                        state_reg  <= B_IDLE;
                    end
                    else if (req_reg.kind != oaht_pkg::OP_INSERT && is_live
                             && key_q == req_reg.key)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= B_IDLE;
                        if (req_reg.kind == oaht_pkg::OP_REMOVE)
                        begin
                            status_reg     <= oaht_pkg::ST_REMOVED;
                            live_reg       <= live_reg - CNTW'(1);
                            del_reg        <= del_reg + CNTW'(1);
                            item_count_reg <= oaht_pkg::CNT_W'(live_reg - CNTW'(1));
                        end
                        else
                        begin
                            status_reg    <= oaht_pkg::ST_FOUND;
                            value_out_reg <= val_q;
                        end
                    end
                    else if (n_reg == LAST)
                    begin
                        done_reg   <= 1'b1;
                        state_reg  <= B_IDLE;
                        status_reg <= (req_reg.kind == oaht_pkg::OP_INSERT)
                                    ? oaht_pkg::ST_FULL : oaht_pkg::ST_NOT_FOUND;
                    end
                    else
                    begin
                        slot_reg  <= slot_step;
                        n_reg     <= n_reg + IDX_W'(1);
                        state_reg <= B_READ;
                    end
                end
                default: state_reg <= B_CLEAR;
            endcase
        end
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign value_out  = value_out_reg;
    assign item_count = item_count_reg;

    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !done)
        else $error("result during clearing pass");

    a_slot_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (CMPW'(live_reg) + CMPW'(del_reg)) <= CMPW'(CAPACITY))
        else $error("live plus deleted exceeds capacity");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done) |-> ($past(state_reg) == B_EVAL || $past(state_reg) == B_IDLE))
        else $error("result from unexpected state");

endmodule

// ===== design/open_address_hash_table.sv =====
// Top level of the open-address hash table.
//
//  channel  | handshake                     | payload
//  ---------+-------------------------------+------------------------------
//  request  | start / busy                  | mode, key, value
//  result   | done (one-cycle strobe)       | status, value_out, item_count
//  config   | cfg_valid / cfg_ready         | cfg_data (load_limit)
//
// Each probe of a slot is a registered memory read, then a compare. The
// front end computes the home slot, by a reduction over the product's
// nibbles when CAPACITY is not a power of two; the back end probes from it.
// After reset the slot values are cleared, one slot at a time, with busy high.
// Results cannot be held off; a two-entry queue lets the front take requests
// while the back end probes.
module open_address_hash_table #(
    parameter int CAPACITY = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [oaht_pkg::MODE_W-1:0]  mode,
    input  logic [oaht_pkg::KEY_W-1:0]   key,
    input  logic [oaht_pkg::VAL_W-1:0]   value,
    output logic                         done,
    output logic [oaht_pkg::STAT_W-1:0]  status,
    output logic [oaht_pkg::VAL_W-1:0]   value_out,
    output logic [oaht_pkg::CNT_W-1:0]   item_count,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [oaht_pkg::CNT_W-1:0]   cfg_data
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int REQ_W = $bits(oaht_pkg::req_t);
    localparam int Q_W   = REQ_W + IDX_W;

    logic [oaht_pkg::CNT_W-1:0] load_limit_reg;
    logic                       front_busy;
    logic                       clearing;
    logic                       q_full;
    logic                       q_empty;
    logic                       q_push;
    logic                       q_pop;
    oaht_pkg::req_t             f_req;
    logic [IDX_W-1:0]           f_home;
    logic [Q_W-1:0]             q_out;
    oaht_pkg::req_t             b_req;
    logic [IDX_W-1:0]           b_home;

    assign cfg_ready = 1'b1;
    assign busy      = front_busy || clearing;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            load_limit_reg <= oaht_pkg::LOAD_LIMIT_RESET;
        else if (cfg_valid && cfg_ready)
            load_limit_reg <= cfg_data;
    end

    oaht_front #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start && !clearing),
        .mode       (mode),
        .key        (key),
        .value      (value),
        .front_busy (front_busy),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_req      (f_req),
        .q_home     (f_home)
    );

    oaht_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({f_req, f_home}),
        .pop       (q_pop),
        .pop_data  (q_out),
        .full      (q_full),
        .empty     (q_empty)
    );

    assign b_req  = q_out[Q_W-1:IDX_W];
    assign b_home = q_out[IDX_W-1:0];

    oaht_back #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_limit (load_limit_reg),
        .q_empty    (q_empty),
        .q_req      (b_req),
        .q_home     (b_home),
        .q_pop      (q_pop),
        .clearing   (clearing),
        .done       (done),
        .status     (status),
        .value_out  (value_out),
        .item_count (item_count)
    );

endmodule

// ===== dv/tb_open_address_hash_table.sv =====
// Testbench for open_address_hash_table: queued requests, slot-level predictor, result check.
module tb_open_address_hash_table;

    localparam int CAP = 1024;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        logic [oaht_pkg::MODE_W-1:0] mode;
        logic [oaht_pkg::KEY_W-1:0]  key;
        logic [oaht_pkg::VAL_W-1:0]  value;
    } request_t;

    typedef struct {
        logic [oaht_pkg::STAT_W-1:0] status;
        logic [oaht_pkg::VAL_W-1:0]  value_out;
        logic [oaht_pkg::CNT_W-1:0]  item_count;
    } outcome_t;

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic [oaht_pkg::MODE_W-1:0]   mode;
    logic [oaht_pkg::KEY_W-1:0]    key;
    logic [oaht_pkg::VAL_W-1:0]    value;
    logic                          done;
    logic [oaht_pkg::STAT_W-1:0]   status;
    logic [oaht_pkg::VAL_W-1:0]    value_out;
    logic [oaht_pkg::CNT_W-1:0]    item_count;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [oaht_pkg::CNT_W-1:0]    cfg_data;

    request_t pending_reqs[$];
    outcome_t expected_outcomes[$];

    logic [oaht_pkg::VAL_W-1:0] tbl_values[CAP];
    logic [oaht_pkg::KEY_W-1:0] tbl_keys[CAP];
    int unsigned      live_cnt;
    int unsigned      dead_cnt;
    int unsigned      limit_reg;

    logic [oaht_pkg::KEY_W-1:0] key_pool[64];
    logic [oaht_pkg::VAL_W-1:0] val_pool[64];

    int  gap_left;
    bit  failed;
    int  stall_cycles;

    open_address_hash_table #(.CAPACITY(CAP)) uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .mode(mode), .key(key), .value(value),
        .done(done), .status(status), .value_out(value_out), .item_count(item_count),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic int unsigned home_of(logic [oaht_pkg::KEY_W-1:0] k);
        logic [oaht_pkg::KEY_W-1:0] h;
        h = k * 64'd73;
        return 32'(h % 64'(CAP));
    endfunction

    function automatic int find_live_key(logic [oaht_pkg::KEY_W-1:0] k);
        int unsigned s;
        s = home_of(k);
        for (int n = 0; n < CAP; n++)
        begin
            if (tbl_values[s] == oaht_pkg::VAL_EMPTY)
                return -1;
            if (tbl_values[s] != oaht_pkg::VAL_DELETED && tbl_keys[s] == k)
                return s;
            s = (s + oaht_pkg::PROBE_STEP) % CAP;
        end
        return -1;
    endfunction

    function automatic logic [oaht_pkg::STAT_W-1:0] apply_insert(
        logic [oaht_pkg::KEY_W-1:0] k,
        logic [oaht_pkg::VAL_W-1:0] v
    );
        int unsigned s;
        s = home_of(k);
        if (v == oaht_pkg::VAL_EMPTY || v == oaht_pkg::VAL_DELETED)
            return oaht_pkg::ST_RESERVED;
        for (int n = 0; n < CAP; n++)
        begin
            if (tbl_values[s] == oaht_pkg::VAL_EMPTY || tbl_values[s] == oaht_pkg::VAL_DELETED)
            begin
                if (tbl_values[s] == oaht_pkg::VAL_EMPTY)
                begin
                    if (live_cnt + dead_cnt >= limit_reg)
                        return oaht_pkg::ST_FULL;
                end
                else
                    dead_cnt--;
                live_cnt++;
                tbl_values[s] = v;
                tbl_keys[s] = k;
                return oaht_pkg::ST_INSERTED;
            end
            if (tbl_values[s] == v)
                return oaht_pkg::ST_PRESENT;
            s = (s + oaht_pkg::PROBE_STEP) % CAP;
        end
        return oaht_pkg::ST_FULL;
    endfunction

    function automatic outcome_t apply_request(request_t r);
        outcome_t o;
        int s;
        o.status = oaht_pkg::ST_NOT_FOUND;
        o.value_out = '0;
        if (r.mode == oaht_pkg::MODE_INSERT)
            o.status = apply_insert(r.key, r.value);
        else if (r.mode == oaht_pkg::MODE_REMOVE)
        begin
            s = find_live_key(r.key);
            if (s >= 0)
            begin
                tbl_values[s] = oaht_pkg::VAL_DELETED;
                live_cnt--;
                dead_cnt++;
                o.status = oaht_pkg::ST_REMOVED;
            end
        end
        else if (r.mode == oaht_pkg::MODE_LOOKUP)
        begin
            s = find_live_key(r.key);
            if (s >= 0)
            begin
                o.value_out = tbl_values[s];
                o.status = oaht_pkg::ST_FOUND;
            end
        end
        o.item_count = live_cnt[oaht_pkg::CNT_W-1:0];
        return o;
    endfunction

    // Driver
    always @(posedge clk or negedge rst_n)
    begin
        request_t r;
        bit       sending;
        if (!rst_n)
        begin
            start <= 1'b0;
            mode  <= '0;
            key   <= '0;
            value <= '0;
            gap_left <= 0;
        end
        else
        begin
            sending = start;
            if (start && !busy)
            begin
                r.mode = mode;
                r.key = key;
                r.value = value;
                expected_outcomes.push_back(apply_request(r));
                sending = 1'b0;
            end
            if (!sending)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    start <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    r = pending_reqs.pop_front();
                    mode  <= r.mode;
                    key   <= r.key;
                    value <= r.value;
                    start <= 1'b1;
                    gap_left <= $urandom_range(0, 10);
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor
    always @(posedge clk)
    begin
        outcome_t e;
        if (rst_n && done)
        begin
            if (expected_outcomes.size() == 0)
            begin
                $display("%0t: unexpected result status=%0d value_out=%h item_count=%0d",
                         $time, status, value_out, item_count);
                failed = 1'b1;
            end
            else
            begin
                e = expected_outcomes.pop_front();
                if (status !== e.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, e.status, status);
                    failed = 1'b1;
                end
                if (value_out !== e.value_out)
                begin
                    $display("%0t: value_out expected %h actual %h", $time, e.value_out,
                             value_out);
                    failed = 1'b1;
                end
                if (item_count !== e.item_count)
                begin
                    $display("%0t: item_count expected %0d actual %0d", $time, e.item_count,
                             item_count);
                    failed = 1'b1;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready) || !rst_n)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic push_req(
        logic [oaht_pkg::MODE_W-1:0] m,
        logic [oaht_pkg::KEY_W-1:0]  k,
        logic [oaht_pkg::VAL_W-1:0]  v
    );
        request_t r;
        r.mode = m;
        r.key = k;
        r.value = v;
        pending_reqs.push_back(r);
    endtask

    task automatic push_random(int count);
        int pick;
        logic [oaht_pkg::MODE_W-1:0] m;
        logic [oaht_pkg::KEY_W-1:0]  k;
        logic [oaht_pkg::VAL_W-1:0]  v;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                m = oaht_pkg::MODE_INSERT;
            else if (pick < 65)
                m = oaht_pkg::MODE_REMOVE;
            else if (pick < 95)
                m = oaht_pkg::MODE_LOOKUP;
            else
                m = oaht_pkg::MODE_UNUSED;
            k = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, 63)] : rand64();
            pick = $urandom_range(0, 99);
            if (pick < 5)
                v = 64'($urandom_range(0, 1));
            else if (pick < 25)
                v = val_pool[$urandom_range(0, 63)];
            else
                v = rand64();
            push_req(m, k, v);
        end
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() > 0 || start || expected_outcomes.size() > 0)
            @(negedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_limit(logic [oaht_pkg::CNT_W-1:0] lim);
        cfg_valid <= 1'b1;
        cfg_data  <= lim;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        limit_reg = lim;
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [oaht_pkg::KEY_W-1:0] k1;
        int unsigned limits[5];
        limits = '{1024, 1, 40, 1023, 870};
        failed = 1'b0;
        stall_cycles = 0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        for (int i = 0; i < CAP; i++)
        begin
            tbl_values[i] = oaht_pkg::VAL_EMPTY;
            tbl_keys[i] = '0;
        end
        live_cnt = 0;
        dead_cnt = 0;
        limit_reg = oaht_pkg::LOAD_LIMIT_RESET;
        for (int i = 0; i < 64; i++)
        begin
            key_pool[i] = rand64();
            val_pool[i] = rand64();
        end
        k1 = rand64();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed
        push_req(oaht_pkg::MODE_INSERT, 64'd5, oaht_pkg::VAL_EMPTY);
        push_req(oaht_pkg::MODE_INSERT, 64'd5, oaht_pkg::VAL_DELETED);
        push_req(oaht_pkg::MODE_INSERT, '0, '1);
        push_req(oaht_pkg::MODE_INSERT, '1, 64'd2);
        push_req(oaht_pkg::MODE_INSERT, '1, 64'd2);
        push_req(oaht_pkg::MODE_LOOKUP, '0, '0);
        push_req(oaht_pkg::MODE_LOOKUP, '1, '1);
        push_req(oaht_pkg::MODE_LOOKUP, 64'd77, '0);
        push_req(oaht_pkg::MODE_REMOVE, '0, '0);
        push_req(oaht_pkg::MODE_REMOVE, '0, '0);
        push_req(oaht_pkg::MODE_LOOKUP, '0, '0);
        // same home slot: k1 and k1+CAP; deleted slot reused ahead of a live duplicate
        push_req(oaht_pkg::MODE_INSERT, k1, 64'h1234);
        push_req(oaht_pkg::MODE_INSERT, k1 + CAP, 64'h5678);
        push_req(oaht_pkg::MODE_REMOVE, k1, '0);
        push_req(oaht_pkg::MODE_INSERT, k1 + CAP, 64'h5678);
        push_req(oaht_pkg::MODE_LOOKUP, k1 + CAP, '0);
        push_req(oaht_pkg::MODE_UNUSED, rand64(), rand64());
        push_req(oaht_pkg::MODE_LOOKUP, k1, '0);
        push_random(60);

        for (int p = 0; p < 5; p++)
        begin
            wait_idle();
            write_limit(oaht_pkg::CNT_W'(limits[p]));
            push_random(p == 1 ? 60 : 180);
        end

        wait_idle();
        repeat (50) @(posedge clk);
        if (!failed)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
